FILE: design/dd_pkg.sv
// Shared types, constants and a helper function for the date difference unit.
// No dependencies; every other file in design/ refers to this package.
`default_nettype none

package dd_pkg;

   localparam int MAX_YEAR      = 9999;
   localparam int YEAR_W        = 14;
   localparam int MONTH_W       = 4;
   localparam int DAY_W         = 5;
   localparam int COUNT_W       = 22;
   localparam int ACC_W         = 23;
   localparam int PROD_W        = 2 * YEAR_W;
   localparam int QUOT_W        = 8;
   localparam int RECIP_SHIFT   = 20;
   localparam int DAY_COUNT_MAX = 3652058;

   // ceil(2^20 / 100): exact quotient by 100 for every 14-bit year
   localparam logic [YEAR_W-1:0] RECIP_100     = 14'd10486;
   localparam logic [YEAR_W-1:0] DAYS_PER_YEAR = 14'd365;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_W-1:0] FEB_LEAP   = 5'd29;
   localparam logic [DAY_W-1:0] FEB_COMMON = 5'd28;

   // index 0 is January; February is handled apart
   localparam logic [11:0][DAY_W-1:0] MONTH_LEN = {
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
      5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd31
   };

   typedef logic [ACC_W-1:0]  acc_type;
   typedef logic [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  first_year;
      logic [MONTH_W-1:0] first_month;
      logic [DAY_W-1:0]   first_day;
      logic [YEAR_W-1:0]  second_year;
      logic [MONTH_W-1:0] second_month;
      logic [DAY_W-1:0]   second_day;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] day_count;
      logic               bad_date;
   } rsp_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD,
      ACC_SUB,
      ACC_NEG
   } acc_op_type;

   typedef struct packed {
      acc_op_type op;
      acc_type    operand;
   } acc_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_Y,
      ST_DIV_P,
      ST_MUL_YR,
      ST_ADD_YR,
      ST_ADD_Q4,
      ST_SUB_Q,
      ST_ADD_Q400,
      ST_ADD_DAY,
      ST_MONTH,
      ST_DIFF,
      ST_ABS,
      ST_OUT
   } state_type;

   function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
      logic [MONTH_W-1:0] idx;
      logic [DAY_W-1:0]   len;
      idx = m - MONTH_JAN;
      len = '0;
      if (m == MONTH_FEB) begin
         len = leap ? FEB_LEAP : FEB_COMMON;
      end else if (m >= MONTH_JAN && m <= MONTH_DEC) begin
         len = MONTH_LEN[idx];
      end
      return len;
   endfunction

endpackage

`default_nettype wire

FILE: design/dd_mul.sv
// Shared registered multiplier: one product per cycle, ready the next cycle.
// Depends on dd_pkg for widths.
`default_nettype none

module dd_mul (
   input  wire logic                       clock,
   input  wire logic [dd_pkg::YEAR_W-1:0]  mul_a,
   input  wire logic [dd_pkg::YEAR_W-1:0]  mul_b,
   output dd_pkg::prod_type                prod
);

   dd_pkg::prod_type prod_ff;
   dd_pkg::prod_type prod_in;

   assign prod_in = dd_pkg::prod_type'(mul_a) * dd_pkg::prod_type'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: design/dd_acc.sv
// Shared accumulator: one clear, add, subtract or negate per cycle on the day number.
// Depends on dd_pkg for the control struct and operation codes.
`default_nettype none

module dd_acc (
   input  wire logic         clock,
   input  wire dd_pkg::acc_ctl_type ctl,
   output dd_pkg::acc_type   acc
);

   dd_pkg::acc_type acc_ff;
   dd_pkg::acc_type acc_in;
   dd_pkg::acc_type add_a;
   dd_pkg::acc_type add_b;
   dd_pkg::acc_type sum;
   logic            sub;

   always_comb begin
      sub   = (ctl.op == dd_pkg::ACC_SUB) || (ctl.op == dd_pkg::ACC_NEG);
      add_a = (ctl.op == dd_pkg::ACC_NEG) ? '0 : acc_ff;
      add_b = (ctl.op == dd_pkg::ACC_NEG) ? acc_ff : ctl.operand;
      sum   = add_a + (sub ? ~add_b : add_b) + dd_pkg::acc_type'(sub);
      case (ctl.op)
         dd_pkg::ACC_HOLD:  acc_in = acc_ff;
         dd_pkg::ACC_CLEAR: acc_in = '0;
         dd_pkg::ACC_ADD,
         dd_pkg::ACC_SUB,
         dd_pkg::ACC_NEG:   acc_in = sum;
         default:           acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

FILE: design/date_difference_in_days_unit.sv
// Gregorian date difference unit: sequencer over a shared multiplier and
// accumulator. Depends on dd_pkg, dd_mul and dd_acc.
//
// Usage:
//   req_* carries one beat holding two dates (year, month, day). rsp_* returns
//   one beat per request: the absolute number of days between the dates, or
//   bad_date set with a zero count when either date is invalid.
//   Each date is turned into a day number: the year quotients by 100 come
//   from a reciprocal multiply, then the accumulator adds the year terms,
//   the day and one month length per cycle. The two day numbers are then
//   subtracted and the sign dropped.
// Sequencing:
//   The time from acceptance to the result register grows with both month
//   fields, as the month loop in the accumulator sets the spread; a month
//   field above 12 walks the loop through December. req_ready is high only
//   while the sequencer is idle, so a new beat is taken only once the last has left it.
// Stall:
//   The result sits in an output register, so a new request is accepted
//   while rsp_ready is low; its result waits in the last step until the
//   pending beat is taken.
// Reset:
//   Synchronous, active high; clears the sequencer and the result valid.
`default_nettype none

module date_difference_in_days_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire dd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output dd_pkg::rsp_type  rsp_data
);

   // sequencer state
   dd_pkg::state_type state_ff, state_in;
   logic              phase_ff, phase_in;     // 0: first date, 1: second date
   logic              bad_ff, bad_in;
   logic              leap_ff, leap_in;
   logic [dd_pkg::QUOT_W-1:0]  qy_ff, qy_in;  // year / 100
   logic [dd_pkg::QUOT_W-1:0]  qp_ff, qp_in;  // (year - 1) / 100
   logic [dd_pkg::MONTH_W-1:0] month_ff, month_in;
   dd_pkg::acc_type   dn0_ff, dn0_in;
   dd_pkg::req_type   req_ff, req_in;
   dd_pkg::rsp_type   rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // datapath hookup
   logic [dd_pkg::YEAR_W-1:0]  mul_a;
   logic [dd_pkg::YEAR_W-1:0]  mul_b;
   dd_pkg::prod_type           prod;
   dd_pkg::acc_ctl_type        acc_ctl;
   dd_pkg::acc_type            acc;

   // current date operands
   logic [dd_pkg::YEAR_W-1:0]  cur_y;
   logic [dd_pkg::YEAR_W-1:0]  prev_y;
   logic [dd_pkg::MONTH_W-1:0] cur_m;
   logic [dd_pkg::DAY_W-1:0]   cur_d;
   logic [dd_pkg::QUOT_W-1:0]  prod_quot;
   logic                       leap_calc;
   logic                       date_bad;
   logic                       req_fire;

   dd_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   dd_acc u_acc (
      .clock (clock),
      .ctl   (acc_ctl),
      .acc   (acc)
   );

   assign cur_y     = phase_ff ? req_ff.second_year  : req_ff.first_year;
   assign cur_m     = phase_ff ? req_ff.second_month : req_ff.first_month;
   assign cur_d     = phase_ff ? req_ff.second_day   : req_ff.first_day;
   assign prev_y    = cur_y - dd_pkg::YEAR_W'(1);
   assign prod_quot = prod[dd_pkg::RECIP_SHIFT +: dd_pkg::QUOT_W];

   // a century year shows as a step between the two quotients
   assign leap_calc = (cur_y[1:0] == 2'd0) && ((qy_ff == qp_ff) || (qy_ff[1:0] == 2'd0));

   assign date_bad = (cur_y == '0)
                  || (cur_y > dd_pkg::YEAR_W'(dd_pkg::MAX_YEAR))
                  || (cur_m < dd_pkg::MONTH_JAN)
                  || (cur_m > dd_pkg::MONTH_DEC)
                  || (cur_d == '0)
                  || (cur_d > dd_pkg::days_in_month(cur_m, leap_ff));

   assign req_ready = (state_ff == dd_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      bad_in       = bad_ff;
      leap_in      = leap_ff;
      qy_in        = qy_ff;
      qp_in        = qp_ff;
      month_in     = month_ff;
      dn0_in       = dn0_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_a        = prev_y;
      mul_b        = dd_pkg::RECIP_100;
      acc_ctl.op      = dd_pkg::ACC_HOLD;
      acc_ctl.operand = '0;

      case (state_ff)
         dd_pkg::ST_IDLE: begin
            if (req_fire) begin
               req_in   = req_data;
               phase_in = 1'b0;
               bad_in   = 1'b0;
               state_in = dd_pkg::ST_DIV_Y;
            end
         end
         dd_pkg::ST_DIV_Y: begin
            mul_a      = cur_y;
            acc_ctl.op = dd_pkg::ACC_CLEAR;
            state_in   = dd_pkg::ST_DIV_P;
         end
         dd_pkg::ST_DIV_P: begin
            qy_in    = prod_quot;
            mul_a    = prev_y;
            state_in = dd_pkg::ST_MUL_YR;
         end
         dd_pkg::ST_MUL_YR: begin
            qp_in    = prod_quot;
            mul_a    = prev_y;
            mul_b    = dd_pkg::DAYS_PER_YEAR;
            state_in = dd_pkg::ST_ADD_YR;
         end
         dd_pkg::ST_ADD_YR: begin
            acc_ctl.op      = dd_pkg::ACC_ADD;
            acc_ctl.operand = dd_pkg::acc_type'(prod);
            leap_in         = leap_calc;
            state_in        = dd_pkg::ST_ADD_Q4;
         end
         dd_pkg::ST_ADD_Q4: begin
            acc_ctl.op      = dd_pkg::ACC_ADD;
            acc_ctl.operand = dd_pkg::acc_type'(prev_y >> 2);
            state_in        = dd_pkg::ST_SUB_Q;
         end
         dd_pkg::ST_SUB_Q: begin
            acc_ctl.op      = dd_pkg::ACC_SUB;
            acc_ctl.operand = dd_pkg::acc_type'(qp_ff);
            state_in        = dd_pkg::ST_ADD_Q400;
         end
         dd_pkg::ST_ADD_Q400: begin
            acc_ctl.op      = dd_pkg::ACC_ADD;
            acc_ctl.operand = dd_pkg::acc_type'(qp_ff >> 2);
            month_in        = dd_pkg::MONTH_JAN;
            state_in        = dd_pkg::ST_ADD_DAY;
         end
         dd_pkg::ST_ADD_DAY: begin
            acc_ctl.op      = dd_pkg::ACC_ADD;
            acc_ctl.operand = dd_pkg::acc_type'(cur_d);
            bad_in          = bad_ff || date_bad;
            state_in        = dd_pkg::ST_MONTH;
         end
         dd_pkg::ST_MONTH: begin
            // add one whole month per cycle until the date's own month, or past December
            if ((month_ff < cur_m) && (month_ff <= dd_pkg::MONTH_DEC)) begin
               acc_ctl.op      = dd_pkg::ACC_ADD;
               acc_ctl.operand = dd_pkg::acc_type'(dd_pkg::days_in_month(month_ff, leap_ff));
               month_in        = month_ff + dd_pkg::MONTH_JAN;
            end else if (!phase_ff) begin
               dn0_in   = acc;
               phase_in = 1'b1;
               state_in = dd_pkg::ST_DIV_Y;
            end else begin
               state_in = dd_pkg::ST_DIFF;
            end
         end
         dd_pkg::ST_DIFF: begin
            acc_ctl.op      = dd_pkg::ACC_SUB;
            acc_ctl.operand = dn0_ff;
            state_in        = dd_pkg::ST_ABS;
         end
         dd_pkg::ST_ABS: begin
            if (acc[dd_pkg::ACC_W-1]) begin
               acc_ctl.op = dd_pkg::ACC_NEG;
            end
            state_in = dd_pkg::ST_OUT;
         end
         dd_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.day_count = bad_ff ? '0 : acc[dd_pkg::COUNT_W-1:0];
               rsp_in.bad_date  = bad_ff;
               rsp_valid_in     = 1'b1;
               state_in         = dd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      bad_ff   <= bad_in;
      leap_ff  <= leap_in;
      qy_ff    <= qy_in;
      qp_ff    <= qp_in;
      month_ff <= month_in;
      dn0_ff   <= dn0_in;
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an invalid date never carries a count
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_date |-> rsp_data.day_count == '0)
      else $error("bad_date result with nonzero count");

   // the count stays inside the calendar range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.day_count <= dd_pkg::COUNT_W'(dd_pkg::DAY_COUNT_MAX))
      else $error("day_count out of range");

   // an accepted request makes the sequencer busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer did not leave idle after accept");

   // month walk stops one past December
   a_month_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == dd_pkg::ST_MONTH |-> month_ff <= dd_pkg::MONTH_DEC + dd_pkg::MONTH_JAN)
      else $error("month counter overran");

endmodule

`default_nettype wire

FILE: tb/tb_date_difference_in_days_unit.sv
// Testbench for date_difference_in_days_unit: directed corner dates, then random
// date pairs under random req/rsp idling. Depends on dd_pkg and the unit.
// Expected day counts come from a day-number predictor in the scoreboard.
`default_nettype none

module tb_date_difference_in_days_unit;

   // Idling profiles for the sender and the receiver
   typedef enum int {
      IDLE_NONE,
      IDLE_LIGHT,
      IDLE_HEAVY
   } idle_mode_type;

   localparam int YEAR_ALL_ONES = (1 << dd_pkg::YEAR_W) - 1;
   localparam int MAX_SHOWN     = 50;   // cap on printed mismatches

   // Scoreboard: predicts the day gap of each accepted request beat and checks
   // every result beat against the oldest prediction.
   class date_gap_board;
      dd_pkg::rsp_type pending_gaps[$];
      int              error_count;

      static function bit leap_year(int y);
         if (y % 100 == 0) begin
            return (y % 400) == 0;
         end
         return (y % 4) == 0;
      endfunction

      static function int month_length(int y, int m);
         case (m)
            2: begin
               return leap_year(y) ? 29 : 28;
            end
            4, 6, 9, 11: begin
               return 30;
            end
            default: begin
               return 31;
            end
         endcase
      endfunction

      static function bit date_valid(int y, int m, int d);
         if (y == 0 || y > dd_pkg::MAX_YEAR) begin
            return 1'b0;
         end
         if (m < 1 || m > 12) begin
            return 1'b0;
         end
         return d >= 1 && d <= month_length(y, m);
      endfunction

      // 1 January of year 1 is day 1
      static function int serial_day(int y, int m, int d);
         int py;
         int n;
         py = y - 1;
         n  = py * 365 + py / 4 - py / 100 + py / 400;
         for (int k = 1; k < m; k++) begin
            n += month_length(y, k);
         end
         return n + d;
      endfunction

      function dd_pkg::rsp_type predict_gap(dd_pkg::req_type r);
         dd_pkg::rsp_type want;
         int              a;
         int              b;
         int              gap;
         want = '0;
         if (!date_valid(int'(r.first_year), int'(r.first_month), int'(r.first_day)) ||
             !date_valid(int'(r.second_year), int'(r.second_month),
                         int'(r.second_day))) begin
            want.bad_date = 1'b1;
            return want;
         end
         a = serial_day(int'(r.first_year), int'(r.first_month), int'(r.first_day));
         b = serial_day(int'(r.second_year), int'(r.second_month), int'(r.second_day));
         gap = (a > b) ? a - b : b - a;
         want.day_count = gap[dd_pkg::COUNT_W-1:0];
         return want;
      endfunction

      function void note_request(dd_pkg::req_type r);
         pending_gaps.push_back(predict_gap(r));
      endfunction

      function void check_result(dd_pkg::rsp_type got);
         dd_pkg::rsp_type want;
         if (pending_gaps.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN) begin
               $error("result beat with no request outstanding: day_count %0d bad_date %0b",
                      got.day_count, got.bad_date);
            end
            return;
         end
         want = pending_gaps.pop_front();
         if (got.day_count !== want.day_count) begin
            error_count++;
            if (error_count <= MAX_SHOWN) begin
               $error("day_count: expected %0d, actual %0d", want.day_count, got.day_count);
            end
         end
         if (got.bad_date !== want.bad_date) begin
            error_count++;
            if (error_count <= MAX_SHOWN) begin
               $error("bad_date: expected %0b, actual %0b", want.bad_date, got.bad_date);
            end
         end
      endfunction
   endclass

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   dd_pkg::req_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   dd_pkg::rsp_type rsp_data;

   date_gap_board   board;
   idle_mode_type   feed_mode  = IDLE_LIGHT;
   idle_mode_type   drain_mode = IDLE_LIGHT;
   int              ready_hold = 0;

   date_difference_in_days_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Hard stop: far beyond the slowest legal run (longest gaps, stalls and
   // the longest month walk for every beat).
   initial begin
      #25_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watch both channels at each edge. Values read here are the pre-edge ones,
   // since every driver updates with nonblocking assignments. Check the result
   // first so a request accepted on the same edge can never pose as the oldest.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            board.check_result(rsp_data);
         end
         if (req_valid && req_ready) begin
            board.note_request(req_data);
         end
      end
   end

   // Receiver: drop rsp_ready for random stretches, mostly short, a few long;
   // hold it high throughout when no idling is wanted.
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
         rsp_ready  <= 1'b0;
      end else if (drain_mode == IDLE_NONE) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < ((drain_mode == IDLE_HEAVY) ? 45 : 20)) begin
         rsp_ready  <= 1'b0;
         ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 80)
                                                   : $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic int pick_gap(idle_mode_type mode);
      int roll;
      if (mode == IDLE_NONE) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < ((mode == IDLE_HEAVY) ? 30 : 65)) begin
         return 0;
      end
      if (roll < 95) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic dd_pkg::req_type make_req(int y1, int m1, int d1,
                                                int y2, int m2, int d2);
      dd_pkg::req_type r;
      r.first_year   = y1[dd_pkg::YEAR_W-1:0];
      r.first_month  = m1[dd_pkg::MONTH_W-1:0];
      r.first_day    = d1[dd_pkg::DAY_W-1:0];
      r.second_year  = y2[dd_pkg::YEAR_W-1:0];
      r.second_month = m2[dd_pkg::MONTH_W-1:0];
      r.second_day   = d2[dd_pkg::DAY_W-1:0];
      return r;
   endfunction

   // Lean toward the range ends and the century and 400-year boundaries.
   function automatic int pick_year();
      case ($urandom_range(0, 7))
         0: begin
            return $urandom_range(1, 8);
         end
         1: begin
            return $urandom_range(dd_pkg::MAX_YEAR - 8, dd_pkg::MAX_YEAR);
         end
         2: begin
            return $urandom_range(1, dd_pkg::MAX_YEAR / 100) * 100;
         end
         3: begin
            return $urandom_range(1, dd_pkg::MAX_YEAR / 400) * 400 + $urandom_range(0, 2) - 1;
         end
         default: begin
            return $urandom_range(1, dd_pkg::MAX_YEAR);
         end
      endcase
   endfunction

   function automatic void pick_valid_date(output int y, output int m, output int d);
      int len;
      y   = pick_year();
      m   = $urandom_range(1, 12);
      len = date_gap_board::month_length(y, m);
      case ($urandom_range(0, 5))
         0: begin
            d = 1;
         end
         1: begin
            d = len;
         end
         default: begin
            d = $urandom_range(1, len);
         end
      endcase
   endfunction

   // Spoil exactly one field of a valid date.
   function automatic void break_date(inout int y, inout int m, inout int d);
      int len;
      len = date_gap_board::month_length(y, m);
      case ($urandom_range(0, 2))
         0: begin
            m = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15);
         end
         1: begin
            d = (len == 31 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(len + 1, 31);
         end
         default: begin
            y = ($urandom_range(0, 2) == 0) ? 0
                                             : $urandom_range(dd_pkg::MAX_YEAR + 1, YEAR_ALL_ONES);
         end
      endcase
   endfunction

   // Mostly well-formed date pairs with random content; the rest broken
   // dates and raw bit noise.
   function automatic dd_pkg::req_type random_dates();
      int              y1, m1, d1, y2, m2, d2;
      int              kind;
      dd_pkg::req_type r;
      kind = $urandom_range(0, 99);
      pick_valid_date(y1, m1, d1);
      pick_valid_date(y2, m2, d2);
      if (kind < 55) begin
         // two independent dates
      end else if (kind < 75) begin
         // nearby dates: same or adjacent year
         y2 = y1 + $urandom_range(0, 2) - 1;
         if (y2 < 1) begin
            y2 = 1;
         end
         if (y2 > dd_pkg::MAX_YEAR) begin
            y2 = dd_pkg::MAX_YEAR;
         end
         d2 = $urandom_range(1, date_gap_board::month_length(y2, m2));
      end else if (kind < 82) begin
         if ($urandom_range(0, 1) == 0) begin
            y1 = 1;
            m1 = 1;
            d1 = 1;
         end else begin
            y1 = dd_pkg::MAX_YEAR;
            m1 = 12;
            d1 = 31;
         end
      end else if (kind < 91) begin
         case ($urandom_range(0, 2))
            0: begin
               break_date(y1, m1, d1);
            end
            1: begin
               break_date(y2, m2, d2);
            end
            default: begin
               break_date(y1, m1, d1);
               break_date(y2, m2, d2);
            end
         endcase
      end else begin
         r.first_year   = dd_pkg::YEAR_W'($urandom);
         r.first_month  = dd_pkg::MONTH_W'($urandom);
         r.first_day    = dd_pkg::DAY_W'($urandom);
         r.second_year  = dd_pkg::YEAR_W'($urandom);
         r.second_month = dd_pkg::MONTH_W'($urandom);
         r.second_day   = dd_pkg::DAY_W'($urandom);
         return r;
      end
      return make_req(y1, m1, d1, y2, m2, d2);
   endfunction

   // Present one request beat and wait for it to be taken. Lower valid only
   // when a gap is wanted; back-to-back beats keep valid high and just swap
   // the payload on the accepting edge.
   task automatic send_dates(input dd_pkg::req_type r);
      int gap;
      gap = pick_gap(feed_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Drop valid and hold off until every predicted result has been checked.
   // The extra edge lets the monitor log the beat accepted on this one.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_gaps.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random(input int count, input idle_mode_type fmode,
                              input idle_mode_type dmode);
      feed_mode  <= fmode;
      drain_mode <= dmode;
      repeat (count) begin
         send_dates(random_dates());
      end
   endtask

   initial begin
      dd_pkg::req_type corner_dates[$];

      board = new();

      // Corner pairs: range ends both ways, equal dates, leap rules at the
      // 4/100/400 boundaries, every kind of bad field in either date, and
      // all-ones fields.
      corner_dates.push_back(make_req(1, 1, 1, dd_pkg::MAX_YEAR, 12, 31));
      corner_dates.push_back(make_req(dd_pkg::MAX_YEAR, 12, 31, 1, 1, 1));
      corner_dates.push_back(make_req(2024, 6, 15, 2024, 6, 15));
      corner_dates.push_back(make_req(1, 1, 1, 1, 1, 2));
      corner_dates.push_back(make_req(dd_pkg::MAX_YEAR, 12, 30, dd_pkg::MAX_YEAR, 12, 31));
      corner_dates.push_back(make_req(2000, 2, 29, 2000, 3, 1));
      corner_dates.push_back(make_req(1900, 2, 29, 1900, 3, 1));
      corner_dates.push_back(make_req(2004, 2, 29, 2003, 2, 28));
      corner_dates.push_back(make_req(2001, 2, 29, 2001, 1, 1));
      corner_dates.push_back(make_req(1999, 12, 31, 2000, 1, 1));
      corner_dates.push_back(make_req(400, 2, 29, 100, 2, 28));
      corner_dates.push_back(make_req(100, 2, 29, 101, 1, 1));
      corner_dates.push_back(make_req(2020, 0, 10, 2020, 1, 10));
      corner_dates.push_back(make_req(2020, 13, 10, 2020, 1, 10));
      corner_dates.push_back(make_req(YEAR_ALL_ONES, 15, 31, 2020, 1, 1));
      corner_dates.push_back(make_req(2020, 5, 0, 2020, 5, 1));
      corner_dates.push_back(make_req(2023, 4, 31, 2023, 5, 1));
      corner_dates.push_back(make_req(2023, 12, 31, 2023, 1, 1));
      corner_dates.push_back(make_req(0, 6, 1, 1, 6, 1));
      corner_dates.push_back(make_req(dd_pkg::MAX_YEAR + 1, 1, 1, 1, 1, 1));
      corner_dates.push_back(make_req(2020, 1, 1, 2021, 2, 30));
      corner_dates.push_back(make_req(2020, 14, 1, 0, 2, 0));
      corner_dates.push_back(make_req(1, 1, 1, YEAR_ALL_ONES, 15, 31));
      corner_dates.push_back(make_req(2024, 2, 29, 2028, 2, 29));

      // Hold reset from the start, then release it; it is never raised again.
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_dates[i]) begin
         send_dates(corner_dates[i]);
      end

      // Pause the sender until the pipe is empty, then restart cold.
      hold_until_drained();

      // Random pairs in three idling profiles, including a stretch with no
      // idling on either side and one with a slow receiver.
      send_random(700, IDLE_LIGHT, IDLE_LIGHT);
      send_random(250, IDLE_NONE, IDLE_NONE);
      hold_until_drained();
      send_random(600, IDLE_HEAVY, IDLE_HEAVY);

      // Drain, then give a trailing window for any stray result beat.
      hold_until_drained();
      drain_mode <= IDLE_LIGHT;
      repeat (60) @(posedge clock);

      if (board.error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: date_difference_in_days_unit.f
design/dd_pkg.sv
design/dd_mul.sv
design/dd_acc.sv
design/date_difference_in_days_unit.sv
tb/tb_date_difference_in_days_unit.sv
